// ----- sv/brcc_pkg.sv -----
`default_nettype none
package brcc_pkg;

   // map geometry
   localparam int MAP_MAX_WIDTH  = 256;
   localparam int MAP_MAX_HEIGHT = 256;
   localparam int MAP_CELLS      = MAP_MAX_WIDTH * MAP_MAX_HEIGHT;
   localparam int ADDR_W         = $clog2(MAP_CELLS);
   localparam int MW_W           = $clog2(MAP_MAX_WIDTH + 1);
   localparam int MH_W           = $clog2(MAP_MAX_HEIGHT + 1);

   // field widths
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_WIDTH  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_HEIGHT = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RED_MASK   = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RED_SHIFT  = 8'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RED_LOSS   = 8'd4;

   // item kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // saturate a configured width to 1..MAP_MAX_WIDTH
   function automatic logic [MW_W-1:0] clamp_width(logic [8:0] v);
      if (v == 9'd0) begin
         return MW_W'(1);
      end else if (int'(v) > MAP_MAX_WIDTH) begin
         return MW_W'(MAP_MAX_WIDTH);
      end else begin
         return MW_W'(v);
      end
   endfunction

   // saturate a configured height to 1..MAP_MAX_HEIGHT
   function automatic logic [MH_W-1:0] clamp_height(logic [8:0] v);
      if (v == 9'd0) begin
         return MH_W'(1);
      end else if (int'(v) > MAP_MAX_HEIGHT) begin
         return MH_W'(MAP_MAX_HEIGHT);
      end else begin
         return MH_W'(v);
      end
   endfunction

endpackage
`default_nettype wire

// ----- sv/brcc_if.sv -----
`default_nettype none
// request channel: map loads and collision queries
interface brcc_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic        [15:0] pixel_index;
   logic        [31:0] pixel_word;
   logic signed [15:0] player_x;
   logic signed [15:0] player_y;
   logic         [7:0] player_w;
   logic         [7:0] player_h;
   logic signed [15:0] move_dx;
   logic signed [15:0] move_dy;

   modport source (output valid, kind, pixel_index, pixel_word, player_x, player_y,
                   player_w, player_h, move_dx, move_dy, input ready);
   modport sink (input valid, kind, pixel_index, pixel_word, player_x, player_y,
                 player_w, player_h, move_dx, move_dy, output ready);
endinterface

// response channel: allowed move and collision flag
interface brcc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] result_dx;
   logic signed [15:0] result_dy;
   logic               colliding;

   modport source (output valid, result_dx, result_dy, colliding, input ready);
   modport sink (input valid, result_dx, result_dy, colliding, output ready);
endinterface

// register write channel
interface brcc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [brcc_pkg::CSR_INDEX_W-1:0] index;
   logic [brcc_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- sv/brcc_ram.sv -----
`default_nettype none
// simple dual-port ram, one write and one registered read
module brcc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- sv/bitmap_rect_collision_check_top.sv -----
`default_nettype none
// Collision map and rectangle test. For a load word (kind 0) the red channel
// of the pixel word is extracted and the pixel is stored blocked when red is
// zero. A query word (kind 1) passes through the placement and range setup
// states, then one map read per pixel under the moved rectangle (rows outside
// the map are not visited), a drain state for the last map read, and the
// result register until the response is taken; no new word is accepted before
// then. The scan is skipped when the rectangle is empty or its horizontal
// edge lies outside the map, and a scan ends early at the first blocked pixel.
// The single read port of the map memory sets the scan pace.
// The map memory has no reset; entries must be loaded before a query covers
// them. Register writes are always ready and are registered.
module bitmap_rect_collision_check_top (
   input wire logic   clock,
   input wire logic   reset,
   brcc_req_if.sink   req_if,
   brcc_rsp_if.source rsp_if,
   brcc_csr_if.sink   csr_if
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PLACE  = 3'd1;
   localparam logic [2:0] ST_RANGE  = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_DRAIN  = 3'd4;
   localparam logic [2:0] ST_RESULT = 3'd5;

   localparam int AW = brcc_pkg::ADDR_W;
   localparam int WW = brcc_pkg::MW_W;
   localparam int HW = brcc_pkg::MH_W;

   // configuration
   logic  [8:0] map_width_ff;
   logic  [8:0] map_height_ff;
   logic [31:0] red_mask_ff;
   logic  [4:0] red_shift_ff;
   logic  [2:0] red_loss_ff;

   // sequencer
   logic [2:0] state_ff, state_in;
   logic       rd_valid_ff, rd_valid_in;
   logic       hit_ff, hit_in;

   // captured query
   logic signed [15:0] px_ff, px_in, py_ff, py_in, dx_ff, dx_in, dy_ff, dy_in;
   logic        [7:0]  pw_ff, pw_in, ph_ff, ph_in;

   // placement results
   logic               hor_ok_ff, hor_ok_in;
   logic signed [17:0] r0_ff, r0_in, rend_ff, rend_in;
   logic     [WW-1:0]  xs_ff, xs_in, xe_ff, xe_in;

   // scan counters
   logic [WW-1:0] cx_ff, cx_in;
   logic [HW-1:0] cy_ff, cy_in, cy_end_ff, cy_end_in;
   logic [AW-1:0] base_ff, base_in;

   logic [WW-1:0] mw;
   logic [HW-1:0] mh;
   logic          req_fire, rsp_fire;

   // map port signals
   logic          map_wr_en;
   logic [AW-1:0] map_wr_addr;
   logic          map_wr_data;
   logic [AW-1:0] map_rd_addr;
   logic          map_rd_data;
   logic   [31:0] red_shifted;
   logic    [7:0] red;

   assign mw       = brcc_pkg::clamp_width(map_width_ff);
   assign mh       = brcc_pkg::clamp_height(map_height_ff);
   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_fire = rsp_if.valid && rsp_if.ready;

   // register writes
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= 9'd256;
         map_height_ff <= 9'd256;
         red_mask_ff   <= 32'h00FF_0000;
         red_shift_ff  <= 5'd16;
         red_loss_ff   <= 3'd0;
      end else if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            brcc_pkg::CSR_MAP_WIDTH:  map_width_ff  <= csr_if.data[8:0];
            brcc_pkg::CSR_MAP_HEIGHT: map_height_ff <= csr_if.data[8:0];
            brcc_pkg::CSR_RED_MASK:   red_mask_ff   <= csr_if.data;
            brcc_pkg::CSR_RED_SHIFT:  red_shift_ff  <= csr_if.data[4:0];
            brcc_pkg::CSR_RED_LOSS:   red_loss_ff   <= csr_if.data[2:0];
            default: ;
         endcase
      end
   end

   // pixel load: red extraction and map write
   assign red_shifted = ((req_if.pixel_word & red_mask_ff) >> red_shift_ff) << red_loss_ff;
   assign red         = red_shifted[7:0];
   assign map_wr_en   = req_fire && (req_if.kind == brcc_pkg::KIND_LOAD)
                        && (32'(req_if.pixel_index) < 32'(brcc_pkg::MAP_CELLS));
   assign map_wr_addr = AW'(req_if.pixel_index);
   assign map_wr_data = (red == 8'd0);
   assign map_rd_addr = base_ff + AW'(cx_ff);

   brcc_ram #(
      .WIDTH (1),
      .DEPTH (brcc_pkg::MAP_CELLS)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   // sequencer next state
   always_comb begin
      logic signed [16:0] xo, yo;
      logic signed [17:0] xe, ye, mw_s, mh_s;
      logic [WW+HW-1:0]   prod;
      logic               last_col, last_row;

      state_in    = state_ff;
      rd_valid_in = 1'b0;
      hit_in      = hit_ff || (rd_valid_ff && map_rd_data);
      px_in = px_ff; py_in = py_ff; dx_in = dx_ff; dy_in = dy_ff;
      pw_in = pw_ff; ph_in = ph_ff;
      hor_ok_in = hor_ok_ff; r0_in = r0_ff; rend_in = rend_ff;
      xs_in = xs_ff; xe_in = xe_ff;
      cx_in = cx_ff; cy_in = cy_ff; cy_end_in = cy_end_ff; base_in = base_ff;

      xo   = 17'(px_ff) + 17'(dx_ff);
      yo   = 17'(py_ff) + 17'(dy_ff);
      xe   = 18'(xo) + $signed({10'd0, pw_ff});
      ye   = 18'(yo) + $signed({10'd0, ph_ff});
      mw_s = $signed(18'(mw));
      mh_s = $signed(18'(mh));
      prod = HW'(r0_ff) * mw;
      last_col = ({1'b0, cx_ff} + 1'b1) == {1'b0, xe_ff};
      last_row = ({1'b0, cy_ff} + 1'b1) == {1'b0, cy_end_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_if.kind == brcc_pkg::KIND_QUERY)) begin
               px_in    = req_if.player_x;
               py_in    = req_if.player_y;
               pw_in    = req_if.player_w;
               ph_in    = req_if.player_h;
               dx_in    = req_if.move_dx;
               dy_in    = req_if.move_dy;
               hit_in   = 1'b0;
               state_in = ST_PLACE;
            end
         end
         // moved rectangle edges and visible row range
         ST_PLACE: begin
            hor_ok_in = !(xo < 0) && !(xe > mw_s);
            r0_in     = (yo < 0) ? 18'sd0 : 18'(yo);
            rend_in   = (ye > mh_s) ? mh_s : ye;
            xs_in     = WW'(xo);
            xe_in     = WW'(xe);
            state_in  = ST_RANGE;
         end
         // first row address, or no scan at all
         ST_RANGE: begin
            cx_in     = xs_ff;
            cy_in     = HW'(r0_ff);
            cy_end_in = HW'(rend_ff);
            base_in   = AW'(prod);
            if (hor_ok_ff && (pw_ff != 8'd0) && (r0_ff < rend_ff)) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_RESULT;
            end
         end
         // one map read per cycle, row by row
         ST_SCAN: begin
            rd_valid_in = 1'b1;
            if (last_col) begin
               cx_in   = xs_ff;
               cy_in   = cy_ff + 1'b1;
               base_in = base_ff + AW'(mw);
            end else begin
               cx_in = cx_ff + 1'b1;
            end
            if ((last_col && last_row) || hit_in) begin
               state_in = ST_DRAIN;
            end
         end
         // last read lands
         ST_DRAIN: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_valid_ff <= 1'b0;
         hit_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= rd_valid_in;
         hit_ff      <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff     <= px_in;
      py_ff     <= py_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      pw_ff     <= pw_in;
      ph_ff     <= ph_in;
      hor_ok_ff <= hor_ok_in;
      r0_ff     <= r0_in;
      rend_ff   <= rend_in;
      xs_ff     <= xs_in;
      xe_ff     <= xe_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      cy_end_ff <= cy_end_in;
      base_ff   <= base_in;
   end

   // handshakes and result word
   assign req_if.ready     = (state_ff == ST_IDLE);
   assign rsp_if.valid     = (state_ff == ST_RESULT);
   assign rsp_if.result_dx = hit_ff ? 16'sd0 : dx_ff;
   assign rsp_if.result_dy = hit_ff ? 16'sd0 : dy_ff;
   assign rsp_if.colliding = hit_ff;

endmodule
`default_nettype wire
